>>> sv/aafp_pkg.sv
// Shared types, constants and the arctangent table for the aim angle unit.
// No dependencies; every other file imports this package.
`default_nettype none
package aafp_pkg;
	localparam int STEPS = 18;
	localparam int CW = 48;
	localparam int ZW = 26;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [ZW-1:0] zval_t;
	typedef logic [4:0] sidx_t;

	localparam zval_t ATAN_TAB [STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
		26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
		26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29
	};

	localparam logic [16:0] GAIN_Q16 = 17'd107922;
	localparam zval_t DEG90_Z = 26'sd23040;
	localparam zval_t PITCH_LIMIT_Z = 26'sd22784;
	localparam logic signed [17:0] DEG90 = 18'sd23040;
	localparam logic signed [17:0] DEG180 = 18'sd46080;
	localparam logic signed [18:0] DEG180_W = 19'sd46080;
	localparam logic signed [18:0] DEG360_W = 19'sd92160;
	localparam logic signed [17:0] PITCH_LIMIT = 18'sd22784;

	typedef struct packed {
		logic dx_zero;
		logic dx_neg;
		logic dy_zero;
		logic dy_neg;
		logic dz_zero;
		logic dz_neg;
		cval_t pz;
		logic signed [15:0] cp;
		logic signed [16:0] cy;
		logic signed [17:0] gy;
	} side_t;

	function automatic zval_t round_clamp(input zval_t z, input zval_t limit);
		zval_t r;
		r = (z + zval_t'(128)) >>> 8;
		if (r < 0) begin
			r = '0;
		end
		if (r > limit) begin
			r = limit;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

>>> sv/aim_angle_from_positions_unit.sv
// Top level of the aim angle unit: input stages, two CORDIC cell chains, output stage.
// Depends on aafp_pkg and aafp_cordic_cell.
//
// Usage: drive the target and observer positions and the current angles with start
// high for one cycle; a request is taken whenever start is high, since busy stays low.
// A new request may follow in every cycle.
// Each request gives one result: done is high for exactly one cycle with out_pitch
// and out_yaw valid in that cycle.
// The pipeline holds two register stages that form the deltas and scaled inputs,
// eighteen yaw CORDIC cells, one stage that forms the goal yaw, eighteen pitch
// CORDIC cells and the output register.
// Throughput is one request per cycle.
// The receiver cannot stall; every result must be taken in its cycle.
// direct_mode_we writes direct_mode from direct_mode_wdata; write only while idle.
// Reset clears direct_mode and every valid flag, so no result follows a reset.
`default_nettype none
module aim_angle_from_positions_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               direct_mode_we,
	input  wire logic               direct_mode_wdata,
	input  wire logic signed [23:0] target_x,
	input  wire logic signed [23:0] target_y,
	input  wire logic signed [23:0] target_z,
	input  wire logic signed [23:0] observer_x,
	input  wire logic signed [23:0] observer_y,
	input  wire logic signed [23:0] observer_z,
	input  wire logic signed [15:0] current_pitch,
	input  wire logic signed [16:0] current_yaw,
	output logic                    done,
	output logic signed [15:0]      out_pitch,
	output logic signed [17:0]      out_yaw
);
	import aafp_pkg::*;

	logic direct_mode_q;
	logic valid_s1, valid_s2, valid_s3;
	logic signed [24:0] dx_s1, dy_s1, dz_s1;
	logic signed [15:0] cp_s1;
	logic signed [16:0] cy_s1;
	cval_t x_s2, y_s2, x_s3;
	side_t side_s2, side_s3, side_yaw;
	logic [24:0] adx, ady, adz;

	logic  yv [STEPS+1];
	cval_t yx [STEPS+1];
	cval_t yy [STEPS+1];
	zval_t yz [STEPS+1];
	side_t ys [STEPS+1];
	logic  pv [STEPS+1];
	cval_t px [STEPS+1];
	cval_t py [STEPS+1];
	zval_t pz [STEPS+1];
	side_t ps [STEPS+1];

	zval_t a_r, b_r;
	logic signed [17:0] gy, gp_w;
	logic signed [16:0] dp;
	logic signed [17:0] np;
	logic signed [18:0] dyaw, dyaw_w;
	logic signed [19:0] ny;
	side_t sf;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_mode_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			if (direct_mode_we) begin
				direct_mode_q <= direct_mode_wdata;
			end
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= yv[STEPS];
			done <= pv[STEPS];
		end
	end

	assign adx = dx_s1[24] ? 25'(-dx_s1) : 25'(dx_s1);
	assign ady = dy_s1[24] ? 25'(-dy_s1) : 25'(dy_s1);
	assign adz = dz_s1[24] ? 25'(-dz_s1) : 25'(dz_s1);

	always_ff @(posedge clk) begin
		dx_s1 <= 25'(target_x) - 25'(observer_x);
		dy_s1 <= 25'(target_y) - 25'(observer_y);
		dz_s1 <= 25'(target_z) - 25'(observer_z);
		cp_s1 <= current_pitch;
		cy_s1 <= current_yaw;

		x_s2 <= cval_t'({adx, 16'b0});
		y_s2 <= cval_t'({ady, 16'b0});
		side_s2.dx_zero <= (dx_s1 == '0);
		side_s2.dx_neg <= dx_s1[24];
		side_s2.dy_zero <= (dy_s1 == '0);
		side_s2.dy_neg <= dy_s1[24];
		side_s2.dz_zero <= (dz_s1 == '0);
		side_s2.dz_neg <= dz_s1[24];
		side_s2.pz <= cval_t'(adz * GAIN_Q16);
		side_s2.cp <= cp_s1;
		side_s2.cy <= cy_s1;
		side_s2.gy <= '0;
	end

	assign yv[0] = valid_s2;
	assign yx[0] = x_s2;
	assign yy[0] = y_s2;
	assign yz[0] = '0;
	assign ys[0] = side_s2;

	assign pv[0] = valid_s3;
	assign px[0] = x_s3;
	assign py[0] = side_s3.pz;
	assign pz[0] = '0;
	assign ps[0] = side_s3;

	for (genvar k = 0; k < STEPS; k++) begin : g_chain
		aafp_cordic_cell u_yaw (
			.clk(clk), .arst_n(arst_n), .idx(sidx_t'(k)), .in_valid(yv[k]),
			.x_in(yx[k]), .y_in(yy[k]), .z_in(yz[k]), .side_in(ys[k]),
			.valid_q(yv[k+1]), .x_q(yx[k+1]), .y_q(yy[k+1]), .z_q(yz[k+1]),
			.side_q(ys[k+1])
		);
		aafp_cordic_cell u_pitch (
			.clk(clk), .arst_n(arst_n), .idx(sidx_t'(k)), .in_valid(pv[k]),
			.x_in(px[k]), .y_in(py[k]), .z_in(pz[k]), .side_in(ps[k]),
			.valid_q(pv[k+1]), .x_q(px[k+1]), .y_q(py[k+1]), .z_q(pz[k+1]),
			.side_q(ps[k+1])
		);
	end

	always_comb begin
		a_r = round_clamp(yz[STEPS], DEG90_Z);
		side_yaw = ys[STEPS];
		if (side_yaw.dx_zero) begin
			gy = side_yaw.dy_zero ? 18'sd0 : (side_yaw.dy_neg ? -DEG90 : DEG90);
		end else if (side_yaw.dy_zero) begin
			gy = side_yaw.dx_neg ? DEG180 : 18'sd0;
		end else if (!side_yaw.dx_neg) begin
			gy = side_yaw.dy_neg ? -18'(a_r) : 18'(a_r);
		end else if (!side_yaw.dy_neg) begin
			gy = DEG180 - 18'(a_r);
		end else begin
			gy = 18'(a_r) - DEG180;
			if (gy == -DEG180) begin
				gy = DEG180;
			end
		end
		side_yaw.gy = gy;
	end

	always_ff @(posedge clk) begin
		x_s3 <= yx[STEPS];
		side_s3 <= side_yaw;
	end

	always_comb begin
		sf = ps[STEPS];
		b_r = round_clamp(pz[STEPS], PITCH_LIMIT_Z);
		if (sf.dx_zero && sf.dy_zero) begin
			gp_w = sf.dz_zero ? 18'sd0 : (sf.dz_neg ? PITCH_LIMIT : -PITCH_LIMIT);
		end else if (sf.dz_zero) begin
			gp_w = '0;
		end else begin
			gp_w = sf.dz_neg ? 18'(b_r) : -18'(b_r);
		end
		dp = 17'(gp_w) - 17'(sf.cp);
		np = 18'(sf.cp) + 18'(dp >>> 1);
		if (np > PITCH_LIMIT) begin
			np = PITCH_LIMIT;
		end
		if (np < -PITCH_LIMIT) begin
			np = -PITCH_LIMIT;
		end
		dyaw = 19'(sf.gy) - 19'(sf.cy);
		dyaw_w = dyaw;
		if (dyaw < -DEG180_W) begin
			dyaw_w = dyaw + DEG360_W;
		end else if (dyaw > DEG180_W) begin
			dyaw_w = dyaw - DEG360_W;
		end
		ny = 20'(sf.cy) + 20'(dyaw_w >>> 1);
	end

	always_ff @(posedge clk) begin
		if (direct_mode_q) begin
			out_pitch <= 16'(gp_w);
			out_yaw <= sf.gy;
		end else begin
			out_pitch <= 16'(np);
			out_yaw <= 18'(ny);
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##40 done)
		else $error("request did not produce a result after the pipeline latency");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_pitch <= 16'sd22784 && out_pitch >= -16'sd22784))
		else $error("pitch result outside the clamp range");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 40))
		else $error("result without a matching request");
endmodule
`default_nettype wire

>>> sv/aafp_cordic_cell.sv
// One vectoring rotation step of the arctangent chain, with its side data.
// Depends on aafp_pkg for the value types and the arctangent table.
`default_nettype none
module aafp_cordic_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire aafp_pkg::sidx_t idx,
	input  wire logic           in_valid,
	input  wire aafp_pkg::cval_t x_in,
	input  wire aafp_pkg::cval_t y_in,
	input  wire aafp_pkg::zval_t z_in,
	input  wire aafp_pkg::side_t side_in,
	output logic                valid_q,
	output aafp_pkg::cval_t     x_q,
	output aafp_pkg::cval_t     y_q,
	output aafp_pkg::zval_t     z_q,
	output aafp_pkg::side_t     side_q
);
	import aafp_pkg::*;

	cval_t xs, ys;

	assign xs = x_in >>> idx;
	assign ys = y_in >>> idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_in;
		if (y_in >= 0) begin
			x_q <= x_in + ys;
			y_q <= y_in - xs;
			z_q <= z_in + ATAN_TAB[idx];
		end else begin
			x_q <= x_in - ys;
			y_q <= y_in + xs;
			z_q <= z_in - ATAN_TAB[idx];
		end
	end
endmodule
`default_nettype wire
